// ===== hw/rtl/pne_pkg.sv =====
// Shared constants and types for the pulse/noise excitation generator.
// No dependencies; imported by every module of the block.
package pne_pkg;

  localparam int unsigned PERIOD_FRAC_BITS_DEF = 8;
  localparam int unsigned PERIOD_INT_BITS_DEF  = 12;

  // Configuration registers are 10 bits; a frame length needs one more bit for 1024.
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned FP_W      = CFG_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned SAMPLE_W = 16;

  localparam logic [CFG_W-1:0]    FRAME_LEN_RST     = 10'd80;
  localparam logic [CFG_W-1:0]    INTERP_PERIOD_RST = 10'd1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX        = 16'h7FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LEN     = 2'd0,
    REG_INTERP_PERIOD = 2'd1
  } cfg_reg_e;

endpackage

// ===== hw/rtl/pne_step_div.sv =====
// Bit-serial period increment unit: |diff| * interp by shift-add, then a
// restoring divide by the frame length, one quotient bit per cycle.
// Depends on pne_pkg.
module pne_step_div import pne_pkg::*; #(
  parameter int unsigned ACC_W = PERIOD_INT_BITS_DEF + PERIOD_FRAC_BITS_DEF + 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W:0]   diff_i,    // two's complement target - current
  input  logic [CFG_W-1:0] interp_i,
  input  logic [FP_W-1:0]  fp_i,
  output logic             done_o,
  output logic [ACC_W-1:0] step_o     // two's complement, saturated
);

  localparam int unsigned PW    = ACC_W + CFG_W;
  localparam int unsigned CNT_W = $clog2(PW + 1);

  localparam logic [ACC_W-1:0] STEP_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] STEP_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_ABS  = 5'b00010,
    D_MUL  = 5'b00100,
    D_DIV  = 5'b01000,
    D_OUT  = 5'b10000
  } div_state_e;

  div_state_e       state_q, state_d;
  logic [ACC_W:0]   diff_q, diff_d;
  logic             neg_q, neg_d;
  logic [PW-1:0]    mcand_q, mcand_d;
  logic [CFG_W-1:0] mplier_q, mplier_d;
  logic [PW-1:0]    acc_q, acc_d;
  logic [FP_W-1:0]  rem_q, rem_d;
  logic [FP_W-1:0]  fp_q, fp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] step_q, step_d;
  logic             done_q, done_d;

  logic [ACC_W:0]   abs_diff;
  logic [FP_W:0]    rem_sh;
  logic [FP_W+1:0]  rem_sub;
  logic             qbit;
  logic             ovf;

  assign abs_diff = diff_q[ACC_W] ? (~diff_q + 1'b1) : diff_q;
  assign rem_sh   = {rem_q, acc_q[PW-1]};
  assign rem_sub  = {1'b0, rem_sh} - {2'b00, fp_q};
  assign qbit     = ~rem_sub[FP_W+1];
  assign ovf      = |acc_q[PW-1:ACC_W-1];

  always_comb begin
    state_d  = state_q;
    diff_d   = diff_q;
    neg_d    = neg_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    fp_d     = fp_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    done_d   = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          diff_d   = diff_i;
          mplier_d = interp_i;
          fp_d     = fp_i;
          state_d  = D_ABS;
        end
      end
      D_ABS: begin
        neg_d   = diff_q[ACC_W];
        mcand_d = PW'(abs_diff[ACC_W-1:0]);
        acc_d   = '0;
        cnt_d   = CNT_W'(CFG_W);
        state_d = D_MUL;
      end
      D_MUL: begin
        // accumulate one multiplier bit per cycle
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          cnt_d   = CNT_W'(PW);
          rem_d   = '0;
          state_d = D_DIV;
        end
      end
      D_DIV: begin
        // shift the dividend out at the top, quotient bits in at the bottom
        rem_d = qbit ? rem_sub[FP_W-1:0] : rem_sh[FP_W-1:0];
        acc_d = {acc_q[PW-2:0], qbit};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = D_OUT;
        end
      end
      D_OUT: begin
        if (ovf) begin
          step_d = neg_q ? STEP_MIN : STEP_MAX;
        end else begin
          step_d = neg_q ? (~acc_q[ACC_W-1:0] + 1'b1) : acc_q[ACC_W-1:0];
        end
        done_d  = 1'b1;
        state_d = D_IDLE;
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q   <= diff_d;
    neg_q    <= neg_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    fp_q     <= fp_d;
    step_q   <= step_d;
  end

  assign done_o = done_q;
  assign step_o = step_q;

endmodule

// ===== hw/rtl/pne_isqrt.sv =====
// Bit-serial integer square root: two radicand bits in, one root bit out per cycle.
// Depends on pne_pkg.
module pne_isqrt import pne_pkg::*; #(
  parameter int unsigned DW = 2 * SAMPLE_W   // radicand width, even
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DW-1:0]     value_i,
  output logic              done_o,
  output logic [DW/2-1:0]   root_o
);

  localparam int unsigned RT_W  = DW / 2;
  localparam int unsigned RW    = RT_W + 2;
  localparam int unsigned CNT_W = $clog2(RT_W + 1);

  typedef enum logic [1:0] {
    Q_IDLE = 2'b01,
    Q_RUN  = 2'b10
  } sqrt_state_e;

  sqrt_state_e      state_q, state_d;
  logic [DW-1:0]    val_q, val_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [RT_W-1:0]  root_q, root_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic [RW:0]      rem_sub;

  assign rem_sh  = {rem_q[RW-3:0], val_q[DW-1:DW-2]};
  assign trial   = {root_q, 2'b01};
  assign rem_sub = {1'b0, rem_sh} - {1'b0, trial};

  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      Q_IDLE: begin
        if (start_i) begin
          val_d   = value_i;
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = CNT_W'(RT_W);
          state_d = Q_RUN;
        end
      end
      Q_RUN: begin
        val_d = val_q << 2;
        if (!rem_sub[RW]) begin
          rem_d  = rem_sub[RW-1:0];
          root_d = {root_q[RT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RT_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = Q_IDLE;
        end
      end
      default: begin
        state_d = Q_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/pulse_noise_excitation.sv =====
// Pulse train / noise excitation generator with linear pitch interpolation.
// Instantiates pne_step_div and pne_isqrt; imports pne_pkg.
//
// An item marked prime (tuser) loads the initial pitch period and returns nothing.
// Every other item returns one Q7.8 excitation sample: on voiced frames a pulse of
// height sqrt(period) whenever the phase accumulator reaches the current period and
// zero otherwise, on unvoiced frames (either pitch zero) the noise value of the item.
// At each frame start the item's pitch becomes the frame target and, if voiced, the
// per-update increment (target - current) * interp_period / frame length is computed
// by a bit-serial multiply and restoring divide; the current period then moves by
// that increment every interp_period samples, the first move after half an interval.
// A result passes S_FRAME, S_PHASE, S_CMP (voiced samples only), S_UPD and S_EMIT;
// it also waits for the serial square root when a pulse fires, for the serial
// increment multiply and divide on a voiced frame start, and in S_EMIT while the
// previous sample still waits in the output register. One item is in flight at a
// time; the next item is accepted as soon as the previous one is in the output
// register, even while that result still waits to be taken. There is no clearing
// pass after reset.
// Write configuration only while idle.
module pulse_noise_excitation import pne_pkg::*; #(
  parameter int unsigned PERIOD_FRAC_BITS = PERIOD_FRAC_BITS_DEF,
  parameter int unsigned PERIOD_INT_BITS  = PERIOD_INT_BITS_DEF,
  localparam int unsigned PER_W     = PERIOD_INT_BITS + PERIOD_FRAC_BITS,
  localparam int unsigned IN_DATA_W = ((PER_W + SAMPLE_W + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // pitch_period, noise_sample, zero pad
  input  logic                 s_axis_tuser,   // prime
  // output samples
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SAMPLE_W-1:0]  m_axis_tdata,   // excitation
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned ACC_W = PER_W + 4;
  // radicand is the period rescaled so the root lands in Q7.8
  localparam int unsigned SQ_SH = 16 - PERIOD_FRAC_BITS;
  localparam int unsigned SQ_IN = ACC_W + SQ_SH;
  localparam int unsigned SQ_W  = SQ_IN + (SQ_IN % 2);
  localparam int unsigned RT_W  = SQ_W / 2;
  localparam int unsigned EXT_W = (RT_W > SAMPLE_W) ? RT_W : SAMPLE_W;

  localparam logic [ACC_W-1:0] ONE_SAMPLE = ACC_W'(1) << PERIOD_FRAC_BITS;
  localparam logic [FP_W-1:0]  FP_FULL    = FP_W'(1) << CFG_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FRAME = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_PHASE = 8'b00001000,
    S_CMP   = 8'b00010000,
    S_SQRT  = 8'b00100000,
    S_UPD   = 8'b01000000,
    S_EMIT  = 8'b10000000
  } pne_state_e;

  pne_state_e       state_q, state_d;

  logic [CFG_W-1:0] frame_len_q, interp_period_q;

  logic [ACC_W-1:0] cur_q, cur_d;
  logic [PER_W-1:0] target_q, target_d;
  logic [ACC_W-1:0] phase_q, phase_d;
  logic [ACC_W-1:0] step_q, step_d;
  logic [CFG_W-1:0] fc_q, fc_d;
  logic [CFG_W-1:0] ic_q, ic_d;

  // payload holding registers
  logic [PER_W-1:0]    pitch_q;
  logic [SAMPLE_W-1:0] noise_q;
  logic [SAMPLE_W-1:0] x_q, x_d;
  logic                m_valid_q, m_valid_d;
  logic [SAMPLE_W-1:0] m_data_q;

  logic             s_fire, m_fire;
  logic             load_out;
  logic [PER_W-1:0] s_pitch;
  logic [FP_W-1:0]  fp_eff;

  logic             div_start, div_done;
  logic [ACC_W:0]   div_diff;
  logic [ACC_W-1:0] div_step;

  logic             sqrt_start, sqrt_done;
  logic [SQ_W-1:0]  sqrt_value;
  logic [RT_W-1:0]  sqrt_root;
  logic [EXT_W-1:0] root_ext;

  logic [ACC_W:0]   phase_sum;
  logic [ACC_W:0]   phase_diff;
  logic [ACC_W+1:0] per_sum;
  logic [CFG_W-1:0] ic_dec;
  logic [FP_W-1:0]  fc_inc;
  logic [CFG_W:0]   ic_half;

  assign s_pitch       = s_axis_tdata[PER_W-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // a frame length of zero stands for a 1024-sample frame
  assign fp_eff = (frame_len_q == '0) ? FP_FULL : {1'b0, frame_len_q};

  assign div_diff   = {1'b0, ACC_W'(pitch_q)} - {1'b0, cur_q};
  assign sqrt_value = SQ_W'(cur_q) << SQ_SH;
  assign root_ext   = EXT_W'(sqrt_root);

  assign phase_sum  = {1'b0, phase_q} + {1'b0, ONE_SAMPLE};
  assign phase_diff = {1'b0, phase_q} - {1'b0, cur_q};
  assign per_sum    = {2'b00, cur_q} + {step_q[ACC_W-1], step_q[ACC_W-1], step_q};
  assign ic_dec     = ic_q - 1'b1;
  assign fc_inc     = {1'b0, fc_q} + 1'b1;
  assign ic_half    = ({1'b0, interp_period_q} + 1'b1) >> 1;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    target_d   = target_q;
    phase_d    = phase_q;
    step_d     = step_q;
    fc_d       = fc_q;
    ic_d       = ic_q;
    x_d        = x_q;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser) begin
            // prime: load the initial period and restart the frame
            cur_d    = ACC_W'(s_pitch);
            phase_d  = ACC_W'(s_pitch);
            target_d = s_pitch;
            step_d   = '0;
            fc_d     = '0;
            ic_d     = '0;
          end else begin
            state_d = S_FRAME;
          end
        end
      end
      S_FRAME: begin
        state_d = S_PHASE;
        if (fc_q == '0) begin
          target_d = pitch_q;
          ic_d     = ic_half[CFG_W-1:0];
          if (cur_q != '0 && pitch_q != '0) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            // unvoiced frame: drop the period, park phase at the target
            step_d  = '0;
            phase_d = ACC_W'(pitch_q);
            cur_d   = '0;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          step_d  = div_step;
          state_d = S_PHASE;
        end
      end
      S_PHASE: begin
        if (cur_q == '0) begin
          x_d     = noise_q;
          state_d = S_UPD;
        end else begin
          phase_d = phase_sum[ACC_W] ? '1 : phase_sum[ACC_W-1:0];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (!phase_diff[ACC_W]) begin
          // phase reached the period: fire a pulse
          phase_d    = phase_diff[ACC_W-1:0];
          sqrt_start = 1'b1;
          state_d    = S_SQRT;
        end else begin
          x_d     = '0;
          state_d = S_UPD;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          x_d     = (root_ext > EXT_W'(SAMPLE_MAX)) ? SAMPLE_MAX : root_ext[SAMPLE_W-1:0];
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        ic_d = ic_dec;
        if (ic_dec == '0) begin
          if (per_sum[ACC_W+1]) begin
            cur_d = '0;
          end else if (per_sum[ACC_W]) begin
            cur_d = '1;
          end else begin
            cur_d = per_sum[ACC_W-1:0];
          end
          ic_d = interp_period_q;
        end
        // frame end overrides any interpolation step
        if (fc_inc >= fp_eff) begin
          fc_d  = '0;
          cur_d = ACC_W'(target_q);
        end else begin
          fc_d = fc_inc[CFG_W-1:0];
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register: hold the sample until taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_fire) begin
      m_valid_d = 1'b0;
    end
    if (load_out) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      frame_len_q     <= FRAME_LEN_RST;
      interp_period_q <= INTERP_PERIOD_RST;
      cur_q           <= '0;
      target_q        <= '0;
      phase_q         <= '0;
      step_q          <= '0;
      fc_q            <= '0;
      ic_q            <= '0;
      m_valid_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      target_q  <= target_d;
      phase_q   <= phase_d;
      step_q    <= step_d;
      fc_q      <= fc_d;
      ic_q      <= ic_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_LEN:     frame_len_q     <= cfg_data_i;
          REG_INTERP_PERIOD: interp_period_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      pitch_q <= s_pitch;
      noise_q <= s_axis_tdata[PER_W +: SAMPLE_W];
    end
    x_q <= x_d;
    if (load_out) begin
      m_data_q <= x_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  pne_step_div #(
    .ACC_W (ACC_W)
  ) u_step_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .diff_i   (div_diff),
    .interp_i (interp_period_q),
    .fp_i     (fp_eff),
    .done_o   (div_done),
    .step_o   (div_step)
  );

  pne_isqrt #(
    .DW (SQ_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sqrt_value),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // the serial units only finish while the sequencer waits on them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("increment divider finished outside its wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == S_SQRT)
    else $error("square root finished outside its wait state");

  // a prime transaction produces no sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser |=> state_q == S_IDLE && !$rose(m_axis_tvalid))
    else $error("prime transaction started a sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_EMIT)
    else $error("output valid raised outside the emit step");

endmodule

// ===== test/excitation_checker.sv =====
`timescale 1ns / 1ps
// Checker for the pulse/noise excitation generator: watches the input, output and
// configuration channels, predicts every excitation sample and compares it.
// Depends on pne_pkg for widths, register indexes and reset values.
module excitation_checker import pne_pkg::*; #(
  parameter int unsigned FRAC  = PERIOD_FRAC_BITS_DEF,
  parameter int unsigned INT   = PERIOD_INT_BITS_DEF,
  localparam int unsigned PER_W = INT + FRAC,
  localparam int unsigned ACC_W = PER_W + 4,
  localparam int unsigned IN_W  = ((PER_W + SAMPLE_W + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,   // pitch_period, noise_sample, zero pad
  input  logic                 s_axis_tuser,   // prime
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [SAMPLE_W-1:0]  m_axis_tdata,   // excitation
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam longint ACC_MAX    = (longint'(1) << ACC_W) - 1;
  localparam longint STEP_MAX   = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint STEP_MIN   = -STEP_MAX - 1;
  localparam longint ONE_SAMPLE = longint'(1) << FRAC;
  localparam int     MAX_REPORTS = 10;

  // shadow of the generator state
  logic [CFG_W-1:0]        frame_len;
  logic [CFG_W-1:0]        interp_len;
  logic [ACC_W-1:0]        cur_per;
  logic [PER_W-1:0]        tgt_per;
  logic [ACC_W-1:0]        phase;
  logic signed [ACC_W-1:0] step;
  int unsigned             frame_pos;
  logic [CFG_W-1:0]        interp_pos;

  logic [SAMPLE_W-1:0] excitation_q[$];
  int                  sample_idx;

  // Pulse height in Q7.8: shifting the period up to 16 fraction bits makes the
  // integer root come out with 8 fraction bits.
  function automatic logic [SAMPLE_W-1:0] pulse_height(input logic [ACC_W-1:0] per);
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    sq   = longint'(per) << (16 - FRAC);
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sq) root = trial;
    end
    if (root > 32767) return SAMPLE_MAX;
    return root[SAMPLE_W-1:0];
  endfunction

  // Advance the shadow state by one input item; return 1 when it yields a sample.
  function automatic bit next_excitation(input logic [PER_W-1:0] pitch,
                                         input logic [SAMPLE_W-1:0] noise,
                                         input bit prime,
                                         output logic [SAMPLE_W-1:0] sample);
    longint fp;
    longint diff;
    longint q;
    longint n;
    longint ph;
    sample = '0;
    fp = (frame_len == '0) ? 1024 : longint'(frame_len);
    if (prime) begin
      cur_per    = ACC_W'(pitch);
      phase      = ACC_W'(pitch);
      tgt_per    = pitch;
      step       = '0;
      frame_pos  = 0;
      interp_pos = '0;
      return 1'b0;
    end

    if (frame_pos == 0) begin
      tgt_per = pitch;
      if (cur_per != '0 && tgt_per != '0) begin
        diff = longint'(tgt_per) - longint'(cur_per);
        q    = diff * longint'(interp_len) / fp;
        if (q > STEP_MAX) q = STEP_MAX;
        if (q < STEP_MIN) q = STEP_MIN;
        step = q[ACC_W-1:0];
      end else begin
        // either end unvoiced: whole frame is noise
        step    = '0;
        phase   = ACC_W'(tgt_per);
        cur_per = '0;
      end
      interp_pos = CFG_W'((int'(interp_len) + 1) >> 1);
    end

    if (cur_per == '0) begin
      sample = noise;
    end else begin
      ph    = longint'(phase);
      ph    = (ph > ACC_MAX - ONE_SAMPLE) ? ACC_MAX : ph + ONE_SAMPLE;
      phase = ph[ACC_W-1:0];
      if (phase >= cur_per) begin
        sample = pulse_height(cur_per);
        phase  = phase - cur_per;
      end
    end

    interp_pos = interp_pos - 1'b1;
    if (interp_pos == '0) begin
      n = longint'(cur_per) + longint'(step);
      if (n < 0) n = 0;
      if (n > ACC_MAX) n = ACC_MAX;
      cur_per    = n[ACC_W-1:0];
      interp_pos = interp_len;
    end

    frame_pos++;
    if (longint'(frame_pos) >= fp) begin
      frame_pos = 0;
      cur_per   = ACC_W'(tgt_per);
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      frame_len    = FRAME_LEN_RST;
      interp_len   = INTERP_PERIOD_RST;
      cur_per      = '0;
      tgt_per      = '0;
      phase        = '0;
      step         = '0;
      frame_pos    = 0;
      interp_pos   = '0;
      excitation_q.delete();
      sample_idx   = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_LEN:     frame_len  = cfg_data_i;
          REG_INTERP_PERIOD: interp_len = cfg_data_i;
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (excitation_q.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("%0t: unexpected excitation sample %h", $realtime, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = excitation_q.pop_front();
          if (m_axis_tdata !== want) begin
            if (fail_count_o < MAX_REPORTS)
              $display("%0t: sample %0d excitation expected %h got %h",
                       $realtime, sample_idx, want, m_axis_tdata);
            fail_count_o++;
          end
          sample_idx++;
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (next_excitation(s_axis_tdata[PER_W-1:0], s_axis_tdata[PER_W +: SAMPLE_W],
                            s_axis_tuser, want))
          excitation_q = {excitation_q, want};
      end

      pending_o = excitation_q.size();
    end
  end

endmodule

// ===== test/tb_pulse_noise_excitation.sv =====
`timescale 1ns / 1ps
// Testbench top for pulse_noise_excitation: clock, reset, stimulus, flow control
// and verdict. Depends on pne_pkg, the block and excitation_checker.
module tb_pulse_noise_excitation;
  import pne_pkg::*;

  localparam int unsigned PITCH_W = PERIOD_INT_BITS_DEF + PERIOD_FRAC_BITS_DEF;
  localparam int unsigned IN_W    = ((PITCH_W + SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned PAD_W   = IN_W - PITCH_W - SAMPLE_W;

  localparam int NUM_PHASES     = 13;
  localparam int PHASE_ITEMS    = 106;
  localparam int CALM_PHASES    = 2;    // last phases run without any idling
  localparam int HOLD_PHASE     = 4;    // phase that starts with a long receiver stall
  localparam int LONG_HOLD      = 400;
  // slowest transaction: a voiced sample that runs both the root and the step divide
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;   // pitch_period, noise_sample, zero pad
  logic                 s_axis_tuser  = 1'b0; // prime
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]  m_axis_tdata;         // excitation
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  int fail_count;
  int pending;

  // flow-control knobs shared between the stimulus and the sink
  int tx_pct   = 0;
  int rx_pct   = 0;
  bit hold_req = 1'b0;

  pulse_noise_excitation dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  excitation_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin : clock
    forever #1 clk_i = ~clk_i;
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input logic [PITCH_W-1:0] pitch, input logic [SAMPLE_W-1:0] noise,
                           input bit prime);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, noise, pitch};
    s_axis_tuser  <= prime;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid for a random burst, at the current idling rate.
  task automatic sender_gap();
    if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Stop sending, wait for every outstanding sample, then let a prime item finish too.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sink: ready in random stretches, idle bursts, and one long stall on request.
  initial begin : sink
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run if no channel moves a transaction for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stuck = 0;
      else
        stuck++;
    end
    $display("[pulse_noise_excitation] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0]    flen;
    logic [CFG_W-1:0]    ilen;
    logic [PITCH_W-1:0]  pitch;
    logic [SAMPLE_W-1:0] noise;
    bit                  prime;
    int                  sel;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // No prime since reset: the current period is zero, so noise passes through,
    // whatever the pitch says.
    send_item(20'hFFFFF, 16'h8000, 1'b0);
    send_item(20'h00000, 16'h7FFF, 1'b0);
    settle();

    write_reg(REG_FRAME_LEN, 10'd4);
    write_reg(REG_INTERP_PERIOD, 10'd2);
    send_item(20'h00100, 16'h0000, 1'b1);         // prime: one-sample period, pulse each sample
    send_item(20'h00300, 16'h1234, 1'b0);         // voiced frame, period slides up
    repeat (3) send_item(PITCH_W'($urandom), 16'($urandom), 1'b0);
    send_item(20'h00000, 16'h8000, 1'b0);         // zero target: unvoiced frame
    repeat (3) send_item(20'hFFFFF, 16'($urandom), 1'b0);
    send_item(20'hFFFFF, 16'h7FFF, 1'b0);         // current is zero: still unvoiced
    repeat (3) send_item(20'h00000, 16'($urandom), 1'b0);
    settle();

    // Step far above what the signed step can hold; then shrink the update interval
    // mid-frame so the clipped step is applied until the period pins at its maximum.
    write_reg(REG_FRAME_LEN, 10'd2);
    write_reg(REG_INTERP_PERIOD, 10'd17);
    send_item(20'h00001, 16'h0000, 1'b1);
    send_item(20'hFFFFF, 16'h5A5A, 1'b0);
    settle();
    write_reg(REG_FRAME_LEN, 10'd1023);
    write_reg(REG_INTERP_PERIOD, 10'd1);
    repeat (10) send_item(PITCH_W'($urandom), 16'($urandom), 1'b0);
    settle();

    // Random part: one register setting per phase, extremes first.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          flen = 10'd1;
          ilen = 10'd0;
        end
        1: begin
          flen = 10'd1023;
          ilen = 10'd1023;
        end
        2: begin
          flen = 10'd0;   // acts as 1024
          ilen = 10'd1;
        end
        default: begin
          flen = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 24));
          ilen = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom)
                                             : CFG_W'($urandom_range(0, 2 * int'(flen)));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_FRAME_LEN, flen);
        write_reg(REG_INTERP_PERIOD, ilen);
      end else begin
        write_reg(REG_INTERP_PERIOD, ilen);
        write_reg(REG_FRAME_LEN, flen);
      end

      if (ph >= NUM_PHASES - CALM_PHASES) begin
        tx_pct = 0;
        rx_pct = 0;
      end else begin
        tx_pct = 25 * $urandom_range(0, 2);
        rx_pct = 25 * $urandom_range(0, 2);
      end
      // stall the sink while items keep coming, so the block backs up
      if (ph == HOLD_PHASE) hold_req = 1'b1;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // mostly prime at the start of a phase, rarely elsewhere
        prime = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0);
        sel   = $urandom_range(0, 19);
        if (sel < 3)
          pitch = '0;
        else if (sel < 5)
          pitch = PITCH_W'($urandom);
        else if (sel == 5)
          pitch = ($urandom_range(0, 1) == 0) ? 20'hFFFFF : 20'h00001;
        else
          pitch = PITCH_W'($urandom_range(20'h00100, 20'h02000));
        noise = SAMPLE_W'($urandom);
        send_item(pitch, noise, prime);
        sender_gap();
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("[pulse_noise_excitation] OK");
    end else begin
      $display("[pulse_noise_excitation] ERROR");
    end
    $finish;
  end

endmodule
